// ===== hw/rtl/mmp_pkg.sv =====
// Shared types and code constants for the MIDI message parser.
package mmp_pkg;

    localparam int BYTE_W = 8;
    localparam int MSG_W  = 48;

    // Bits 6:4 of a channel or system status byte.
    localparam logic [2:0] HI_NOTE_OFF  = 3'd0;
    localparam logic [2:0] HI_NOTE_ON   = 3'd1;
    localparam logic [2:0] HI_CC        = 3'd3;
    localparam logic [2:0] HI_PROGRAM   = 3'd4;
    localparam logic [2:0] HI_CHANPRESS = 3'd5;
    localparam logic [2:0] HI_BEND      = 3'd6;
    localparam logic [2:0] HI_SYSTEM    = 3'd7;

    // Low nibble of a system status byte.
    localparam logic [3:0] SYS_SYSEX    = 4'h0;
    localparam logic [3:0] SYS_TIMECODE = 4'h1;
    localparam logic [3:0] SYS_SONGPOS  = 4'h2;
    localparam logic [3:0] SYS_SONGSEL  = 4'h3;

    localparam logic [7:0] VENDOR_CONNTEST = 8'hF1;

    // Message kinds reported on the result channel.
    localparam logic [3:0] KIND_SYSEX    = 4'd7;
    localparam logic [3:0] KIND_CONNTEST = 4'd8;
    localparam logic [3:0] KIND_TIMECODE = 4'd9;
    localparam logic [3:0] KIND_SONGPOS  = 4'd10;
    localparam logic [3:0] KIND_SONGSEL  = 4'd11;
    localparam logic [3:0] KIND_SYSBYTE  = 4'd12;
    localparam logic [3:0] KIND_STRAY    = 4'd13;

    // Decoded message; the first member sits in the highest bits.
    typedef struct packed {
        logic signed [5:0] octave;
        logic [3:0]        pitch_class;
        logic [13:0]       wide_value;
        logic [7:0]        second_data;
        logic [7:0]        first_data;
        logic [3:0]        channel;
        logic [3:0]        kind;
    } msg_t;

endpackage

// ===== hw/rtl/mmp_core.sv =====
// Running-status parse state and combinational message decode.
module mmp_core
    import mmp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_valid,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              advance,
    output logic              res_valid,
    output msg_t              res_msg
);

    logic [7:0] running_status_reg, running_status_next;
    logic [7:0] pending_status_reg, pending_status_next;
    logic [1:0] bytes_needed_reg, bytes_needed_next;
    logic [7:0] held_data_reg, held_data_next;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] n;
        n = 2'd2;
        if (st[6:4] inside {HI_PROGRAM, HI_CHANPRESS}) begin
            n = 2'd1;
        end else if (st[6:4] == HI_SYSTEM) begin
            case (st[3:0])
                SYS_SYSEX, SYS_TIMECODE, SYS_SONGSEL: n = 2'd1;
                SYS_SONGPOS: n = 2'd2;
                default: n = 2'd0;
            endcase
        end
        return n;
    endfunction

    function automatic msg_t emit_msg(input logic [7:0] st, input logic [7:0] d1,
                                      input logic [7:0] d2);
        msg_t       m;
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  q12;
        logic [7:0]  rem;
        m = '0;
        m.first_data = d1;
        // Division by twelve as a multiply by 171/2048, exact for byte inputs.
        prod = {8'b0, d1} * 16'd171;
        quot = prod[15:11];
        q12  = {3'b0, quot} * 8'd12;
        rem  = d1 - q12;
        if (st[6:4] != HI_SYSTEM) begin
            m.kind    = {1'b0, st[6:4]};
            m.channel = st[3:0];
            if (!(st[6:4] inside {HI_PROGRAM, HI_CHANPRESS})) begin
                m.second_data = d2;
            end
            if (st[6:4] == HI_CC) begin
                m.first_data = {1'b0, d1[6:0]};
            end
            if (st[6:4] == HI_BEND) begin
                m.wide_value = {d2[6:0], d1[6:0]};
            end
            if (st[6:4] inside {HI_NOTE_OFF, HI_NOTE_ON}) begin
                m.pitch_class = rem[3:0];
                m.octave      = {1'b0, quot} - 6'd1;
            end
        end else begin
            case (st[3:0])
                SYS_SYSEX: m.kind = (d1 == VENDOR_CONNTEST) ? KIND_CONNTEST : KIND_SYSEX;
                SYS_TIMECODE: m.kind = KIND_TIMECODE;
                SYS_SONGPOS: begin
                    m.kind        = KIND_SONGPOS;
                    m.second_data = d2;
                    m.wide_value  = {d2[6:0], d1[6:0]};
                end
                SYS_SONGSEL: m.kind = KIND_SONGSEL;
                default: begin
                    m.kind       = KIND_SYSBYTE;
                    m.first_data = {4'b0, st[3:0]};
                end
            endcase
        end
        return m;
    endfunction

    always_comb begin
        logic [1:0] n;
        running_status_next = running_status_reg;
        pending_status_next = pending_status_reg;
        bytes_needed_next   = bytes_needed_reg;
        held_data_next      = held_data_reg;
        res_valid           = 1'b0;
        res_msg             = '0;
        n                   = 2'd0;
        if (bytes_needed_reg != 2'd0) begin
            n = data_count(pending_status_reg);
            if (bytes_needed_reg >= 2'd2) begin
                held_data_next    = byte_in;
                bytes_needed_next = 2'd1;
            end else begin
                bytes_needed_next = 2'd0;
                res_valid         = byte_valid;
                if (n >= 2'd2) begin
                    res_msg = emit_msg(pending_status_reg, held_data_reg, byte_in);
                end else begin
                    res_msg = emit_msg(pending_status_reg, byte_in, 8'd0);
                end
            end
        end else if (byte_in[7]) begin
            running_status_next = (byte_in[7:4] == 4'hF) ? 8'd0 : byte_in;
            pending_status_next = byte_in;
            n = data_count(byte_in);
            if (n == 2'd0) begin
                res_valid = byte_valid;
                res_msg   = emit_msg(byte_in, 8'd0, 8'd0);
            end else begin
                bytes_needed_next = n;
            end
        end else if (running_status_reg[7]) begin
            pending_status_next = running_status_reg;
            n = data_count(running_status_reg);
            if (n >= 2'd2) begin
                held_data_next    = byte_in;
                bytes_needed_next = 2'd1;
            end else begin
                res_valid = byte_valid;
                res_msg   = emit_msg(running_status_reg, byte_in, 8'd0);
            end
        end else begin
            res_valid          = byte_valid;
            res_msg.kind       = KIND_STRAY;
            res_msg.first_data = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_status_reg <= 8'd0;
            pending_status_reg <= 8'd0;
            bytes_needed_reg   <= 2'd0;
            held_data_reg      <= 8'd0;
        end else if (advance) begin
            running_status_reg <= running_status_next;
            pending_status_reg <= pending_status_next;
            bytes_needed_reg   <= bytes_needed_next;
            held_data_reg      <= held_data_next;
        end
    end

`ifndef ASSERT_OFF
    a_needed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_needed_reg != 2'd3)
        else $error("Data byte count out of range.");

    a_running_is_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        running_status_reg == 8'd0 ||
        (running_status_reg[7] && running_status_reg[7:4] != 4'hF))
        else $error("Running status holds a non-channel byte.");

    a_pending_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_needed_reg != 2'd0 |-> pending_status_reg[7])
        else $error("Collecting data without a status byte.");
`endif

endmodule

// ===== hw/rtl/midi_message_parser.sv =====
// Top level of the MIDI message parser: input register, parser, result register.
//
// The slave channel takes one MIDI stream byte per request on s_tdata.
// The master channel gives one decoded message per request on m_tdata.
// Status bytes that start a message and the first data byte of a
// two-byte message give no result; the byte that completes a message,
// a data-free system status byte and a stray data byte give one.
// A byte accepted into the input register is parsed from there, and its
// result is loaded into the result register, from which the result is
// offered on the master channel.
// One byte is accepted every cycle as long as the result channel takes
// its requests; the input register and the result register are the two
// pipeline stages.
// When the receiver stalls, a byte that needs to deliver a result waits
// in the input register while s_tready stays high for as long as that
// register is empty; bytes that produce no result keep moving.
// Reset clears running status, the pending message and both valid flags.
module midi_message_parser
    import mmp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,  // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    // [3:0] kind, [7:4] channel, [15:8] first_data, [23:16] second_data,
    // [37:24] wide_value, [41:38] pitch_class, [47:42] octave
    output logic [MSG_W-1:0]  m_tdata
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    msg_t              out_msg_reg;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    msg_t              res_msg;

    mmp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (in_valid_reg),
        .byte_in    (in_byte_reg),
        .advance    (advance),
        .res_valid  (res_valid),
        .res_msg    (res_msg)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_msg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && res_valid) begin
            out_msg_reg <= res_msg;
        end
    end

`ifndef ASSERT_OFF
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid |=> out_valid_reg)
        else $error("Parsed message was not loaded into the result register.");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_msg_reg.kind <= KIND_STRAY)
        else $error("Result carries an unknown message kind.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(advance && res_valid))
        else $error("Pending result would be overwritten.");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the MIDI message parser: directed and random byte streams.
module testbench;
    import mmp_pkg::*;

    localparam logic [2:0] HI_POLYPRESS = 3'd2;
    localparam logic [3:0] SYS_RESET    = 4'hF;
    localparam int         CYCLE_LIMIT  = 400000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [MSG_W-1:0]  m_tdata;

    // Parser state as the stream has left it so far.
    logic [7:0] running_st = '0;
    logic [7:0] pending_st = '0;
    logic [1:0] need_cnt   = '0;
    logic [7:0] held_byte  = '0;

    msg_t decoded_msgs[$];
    int   fail_count = 0;
    int   bytes_sent = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    bit   idling_on = 1'b1;

    midi_message_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] status_byte(input logic [2:0] hi, input logic [3:0] low);
        return {1'b1, hi, low};
    endfunction

    function automatic int data_bytes_for(input logic [7:0] st);
        if (st[6:4] == HI_PROGRAM || st[6:4] == HI_CHANPRESS) begin
            return 1;
        end
        if (st[6:4] != HI_SYSTEM) begin
            return 2;
        end
        case (st[3:0])
            SYS_SYSEX, SYS_TIMECODE, SYS_SONGSEL: return 1;
            SYS_SONGPOS: return 2;
            default: return 0;
        endcase
    endfunction

    function automatic msg_t decode_message(input logic [7:0] st, input logic [7:0] d1,
                                            input logic [7:0] d2);
        msg_t       m;
        logic [2:0] hi;
        hi = st[6:4];
        m = '0;
        m.first_data = d1;
        if (hi != HI_SYSTEM) begin
            m.kind = {1'b0, hi};
            m.channel = st[3:0];
            if (hi != HI_PROGRAM && hi != HI_CHANPRESS) begin
                m.second_data = d2;
            end
            if (hi == HI_CC) begin
                m.first_data = {1'b0, d1[6:0]};
            end
            if (hi == HI_BEND) begin
                m.wide_value = {d2[6:0], d1[6:0]};
            end
            if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON) begin
                m.pitch_class = 4'(d1 % 12);
                m.octave = 6'(d1 / 12) - 6'd1;
            end
        end else begin
            case (st[3:0])
                SYS_SYSEX: m.kind = (d1 == VENDOR_CONNTEST) ? KIND_CONNTEST : KIND_SYSEX;
                SYS_TIMECODE: m.kind = KIND_TIMECODE;
                SYS_SONGPOS: begin
                    m.kind = KIND_SONGPOS;
                    m.second_data = d2;
                    m.wide_value = {d2[6:0], d1[6:0]};
                end
                SYS_SONGSEL: m.kind = KIND_SONGSEL;
                default: begin
                    m.kind = KIND_SYSBYTE;
                    m.first_data = {4'h0, st[3:0]};
                end
            endcase
        end
        return m;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        msg_t m;
        if (need_cnt != 2'd0) begin
            if (need_cnt >= 2'd2) begin
                held_byte = b;
                need_cnt = 2'd1;
            end else begin
                need_cnt = 2'd0;
                if (data_bytes_for(pending_st) >= 2) begin
                    decoded_msgs.push_back(decode_message(pending_st, held_byte, b));
                end else begin
                    decoded_msgs.push_back(decode_message(pending_st, b, 8'h00));
                end
            end
        end else if (b[7]) begin
            running_st = (b[6:4] == HI_SYSTEM) ? 8'h00 : b;
            pending_st = b;
            if (data_bytes_for(b) == 0) begin
                decoded_msgs.push_back(decode_message(b, 8'h00, 8'h00));
            end else begin
                need_cnt = 2'(data_bytes_for(b));
            end
        end else if (running_st[7]) begin
            pending_st = running_st;
            if (data_bytes_for(running_st) >= 2) begin
                held_byte = b;
                need_cnt = 2'd1;
            end else begin
                decoded_msgs.push_back(decode_message(running_st, b, 8'h00));
            end
        end else begin
            m = '0;
            m.kind = KIND_STRAY;
            m.first_data = b;
            decoded_msgs.push_back(m);
        end
    endtask

    // Called just after a rising clock; returns once the parser has taken the request.
    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        parse_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] random_data();
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_random_message();
        logic [7:0] st;
        int         pick;
        int         n;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            send_byte(8'($urandom));
        end else if (pick < 5 && running_st[7]) begin
            repeat (data_bytes_for(running_st)) send_byte(random_data());
        end else begin
            st = status_byte(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
            if (st[6:4] == HI_SYSTEM && $urandom_range(0, 1) == 1) begin
                st[3:0] = 4'($urandom_range(0, 3));
            end
            send_byte(st);
            n = data_bytes_for(st);
            for (int i = 0; i < n; i++) begin
                if (st[3:0] == SYS_SYSEX && st[6:4] == HI_SYSTEM && $urandom_range(0, 1) == 1)
                begin
                    send_byte(VENDOR_CONNTEST);
                end else begin
                    send_byte(random_data());
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        msg_t want;
        msg_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = msg_t'(m_tdata);
            if (decoded_msgs.size() == 0) begin
                $error("unexpected message: kind %0d first_data %0d", got.kind, got.first_data);
                fail_count++;
            end else begin
                want = decoded_msgs.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("channel", want.channel, got.channel);
                check_field("first_data", want.first_data, got.first_data);
                check_field("second_data", want.second_data, got.second_data);
                check_field("wide_value", want.wide_value, got.wide_value);
                check_field("pitch_class", want.pitch_class, got.pitch_class);
                check_field("octave", want.octave, got.octave);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 4) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_channel_messages();
        send_byte(8'h00);
        send_byte(status_byte(HI_NOTE_OFF, 4'hF));
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(status_byte(HI_NOTE_ON, 4'h0));
        send_byte(8'h3C);
        send_byte(8'h40);
        send_byte(status_byte(HI_POLYPRESS, 4'h5));
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(status_byte(HI_CC, 4'h3));
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(status_byte(HI_PROGRAM, 4'h7));
        send_byte(8'h85);
        send_byte(status_byte(HI_CHANPRESS, 4'h0));
        send_byte(8'h55);
        send_byte(status_byte(HI_BEND, 4'hE));
        send_byte(8'h7F);
        send_byte(8'h7F);
    endtask

    task automatic test_system_messages();
        send_byte(status_byte(HI_SYSTEM, SYS_SYSEX));
        send_byte(VENDOR_CONNTEST);
        send_byte(status_byte(HI_SYSTEM, SYS_SYSEX));
        send_byte(8'h42);
        send_byte(status_byte(HI_SYSTEM, SYS_TIMECODE));
        send_byte(8'h12);
        send_byte(status_byte(HI_SYSTEM, SYS_SONGPOS));
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(status_byte(HI_SYSTEM, SYS_SONGSEL));
        send_byte(8'h05);
        send_byte(status_byte(HI_SYSTEM, SYS_RESET));
        send_byte(8'h7F);
    endtask

    task automatic test_random_stream(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            send_random_message();
        end
    endtask

    task automatic test_steady_stream(input int count);
        idling_on = 1'b0;
        test_random_stream(count);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_channel_messages();
        test_system_messages();
        test_random_stream(1200);
        test_steady_stream(400);
        s_tvalid <= 1'b0;
        while (decoded_msgs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
